[src/aes256_cbc_cipher_macros.svh]
// assertion macros for the cipher checker
`ifndef AES256_CBC_CIPHER_MACROS_SVH
`define AES256_CBC_CIPHER_MACROS_SVH
`define AES_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/aes_pkg.sv]
package aes_pkg;

    localparam int NumRounds = 14;
    localparam int KeyWords = 60;
    localparam int KeyRows = NumRounds + 1;
    localparam int NumRegs = 6;
    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] RegKey0 = 3'd0;
    localparam logic [RegIdxW-1:0] RegKey1 = 3'd1;
    localparam logic [RegIdxW-1:0] RegKey2 = 3'd2;
    localparam logic [RegIdxW-1:0] RegKey3 = 3'd3;
    localparam logic [RegIdxW-1:0] RegIvHigh = 3'd4;
    localparam logic [RegIdxW-1:0] RegIvLow = 3'd5;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic        last_block;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
        logic        result_last;
    } aes_out_t;

    typedef enum logic [2:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } aes_state_t;

    typedef struct packed {
        logic       start;
        logic       decrypt;
        logic [3:0] round;
        logic       first;
        logic       last;
    } aes_ctl_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] gfull(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gfull = p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] b);
        logic [7:0] inv;
        logic [7:0] sq;
        inv = 8'h01;
        sq = b;
        for (int k = 0; k < 8; k++) begin
            if (k != 0) inv = gfull(inv, sq);
            sq = gfull(sq, sq);
        end
        ginv = inv;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
        rotl = (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] inv;
        inv = ginv(x);
        sbox = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] sbox_rev(input logic [7:0] y);
        logic [7:0] b;
        b = rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05;
        sbox_rev = ginv(b);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

[src/aes256_cbc_cipher.sv]
// AES-256 CBC block cipher, one 16-byte block per transfer.
// s_ channel: operation (0 encrypt, 1 decrypt), 128-bit block, last mark.
// m_ channel: 128-bit result and the copied last mark.
// cfg port: cfg_we/cfg_idx/cfg_data write key words 0-3 and iv high/low.
// Writing an iv register reloads the chaining value; writing a key word
// reruns the key schedule, one round-key word per cycle.
// After reset the schedule of the all-zero key runs first with s_ready
// low, and the chaining value is zero.
// Each block runs in the shared round unit as a key add plus 14 rounds;
// if the output register is free, the result lands there in the last
// round, and s_ready returns in the next cycle. A new block is taken
// only after the last one has left the round unit.
// The round-key store is read one 128-bit row per cycle.
// If the receiver stalls, the held result stays in the output register
// and one more block is taken and run; its result waits in the round
// unit with s_ready low until the output register is free.
// Users write configuration only with no block in flight; not enforced.
module aes256_cbc_cipher (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  aes_pkg::aes_in_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output aes_pkg::aes_out_t            m_data,
    input  logic                         cfg_we,
    input  logic [aes_pkg::RegIdxW-1:0]  cfg_idx,
    input  logic [63:0]                  cfg_data
);
    import aes_pkg::*;

    aes_state_t state_reg, state_next;
    logic [63:0] key_reg [4];
    logic [63:0] iv_reg [2];
    logic [127:0] chain_reg;
    logic [127:0] rk_mem [KeyRows];
    logic [5:0] xw_reg;
    logic [7:0] rc_reg;
    logic [31:0] w1_reg;
    logic [127:0] st_reg;
    logic [127:0] blk_reg;
    logic op_reg, last_reg;
    logic [3:0] rnd_reg;
    logic [127:0] rk_reg;
    logic [127:0] rnd_out;
    aes_ctl_t ctl;
    aes_out_t out_reg;
    logic out_valid_reg;
    logic out_free;
    logic out_load;
    logic [127:0] fin_word;
    logic [127:0] out_word;
    logic key_wr;
    logic [31:0] xt_word;
    logic [31:0] new_word;
    logic [31:0] old8_reg;
    logic [5:0] old_addr;
    logic [3:0] nxt_key;

    assign key_wr = cfg_we && (cfg_idx == RegKey0 || cfg_idx == RegKey1
                    || cfg_idx == RegKey2 || cfg_idx == RegKey3);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EXPAND: if (xw_reg == 6'(KeyWords - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = ST_ROUND;
            ST_ROUND:  if (rnd_reg == 4'(NumRounds)) state_next = out_free ? ST_IDLE : ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        if (key_wr) state_next = ST_EXPAND;
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = out_valid_reg;
        out_free = !out_valid_reg || m_ready;
        out_load = out_free && ((state_reg == ST_ROUND && rnd_reg == 4'(NumRounds))
                                || state_reg == ST_OUT);
        ctl.start = (state_reg == ST_IDLE) && s_valid;
        ctl.decrypt = op_reg;
        ctl.round = rnd_reg;
        ctl.first = (rnd_reg == 4'd0);
        ctl.last = (rnd_reg == 4'(NumRounds));
    end

    // key schedule word, uses the previous word and the word eight back
    always_comb begin
        xt_word = w1_reg;
        if (xw_reg[2:0] == 3'd0) begin
            xt_word = sub_word({w1_reg[23:0], w1_reg[31:24]}) ^ {rc_reg, 24'h0};
        end else if (xw_reg[2:0] == 3'd4) begin
            xt_word = sub_word(w1_reg);
        end
    end

    assign new_word = (xw_reg < 6'd8) ? (xw_reg[0] ? key_reg[xw_reg[2:1]][31:0]
                                                   : key_reg[xw_reg[2:1]][63:32])
                                      : (old8_reg ^ xt_word);

    assign old_addr = xw_reg - 6'd7;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXPAND) begin
            rk_mem[xw_reg[5:2]][{~xw_reg[1:0], 5'd0} +: 32] <= new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EXPAND;
            xw_reg <= 6'd0;
            rc_reg <= 8'h01;
            key_reg[0] <= '0; key_reg[1] <= '0; key_reg[2] <= '0; key_reg[3] <= '0;
            iv_reg[0] <= '0; iv_reg[1] <= '0;
            chain_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    RegKey0, RegKey1, RegKey2, RegKey3: key_reg[cfg_idx[1:0]] <= cfg_data;
                    RegIvHigh: chain_reg <= {cfg_data, iv_reg[1]};
                    RegIvLow:  chain_reg <= {iv_reg[0], cfg_data};
                    default: ;
                endcase
                if (cfg_idx == RegIvHigh) iv_reg[0] <= cfg_data;
                if (cfg_idx == RegIvLow) iv_reg[1] <= cfg_data;
            end
            if (key_wr) begin
                xw_reg <= 6'd0;
                rc_reg <= 8'h01;
            end else if (state_reg == ST_EXPAND) begin
                xw_reg <= xw_reg + 6'd1;
                if (xw_reg >= 6'd8 && xw_reg[2:0] == 3'd0) rc_reg <= xt(rc_reg);
            end
            if (state_reg == ST_ROUND && rnd_reg == 4'(NumRounds)) begin
                chain_reg <= op_reg ? blk_reg : rnd_out;
            end
        end
    end

    // previous word and the word seven back (read ahead of use)
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXPAND) begin
            w1_reg <= new_word;
            if (xw_reg >= 6'd7) begin
                old8_reg <= rk_mem[old_addr[5:2]][{~old_addr[1:0], 5'd0} +: 32];
            end else begin
                old8_reg <= 32'h0;
            end
        end else begin
            w1_reg <= 32'h0;
            old8_reg <= 32'h0;
        end
    end

    // round key fetch: one row a cycle, registered ahead of the round using it
    always_comb begin
        if (ctl.start) nxt_key = s_data.operation ? 4'(NumRounds) : 4'd0;
        else if (op_reg) nxt_key = 4'(NumRounds) - rnd_reg - 4'd1;
        else nxt_key = rnd_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        rk_reg <= rk_mem[nxt_key];
    end

    aes_round u_round (
        .state_in (st_reg),
        .key_in   (rk_reg),
        .ctl      (ctl),
        .state_out(rnd_out)
    );

    assign fin_word = op_reg ? (rnd_out ^ chain_reg) : rnd_out;
    assign out_word = (state_reg == ST_OUT) ? st_reg : fin_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg <= 4'd0;
        end else if (ctl.start) begin
            rnd_reg <= 4'd0;
            op_reg <= s_data.operation;
            last_reg <= s_data.last_block;
            blk_reg <= {s_data.block_hi, s_data.block_lo};
            st_reg <= (s_data.operation == OpDecrypt) ? {s_data.block_hi, s_data.block_lo}
                    : ({s_data.block_hi, s_data.block_lo} ^ chain_reg);
        end else if (state_reg == ST_ROUND) begin
            rnd_reg <= rnd_reg + 4'd1;
            st_reg <= (rnd_reg == 4'(NumRounds)) ? fin_word : rnd_out;
        end
    end

    // output register, parts the round unit from the receiver
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
            out_reg.result_hi <= out_word[127:64];
            out_reg.result_lo <= out_word[63:0];
            out_reg.result_last <= last_reg;
        end else if (m_valid && m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_data = out_reg;

endmodule

[src/aes_round.sv]
module aes_round (
    input  logic [127:0]    state_in,
    input  logic [127:0]    key_in,
    input  aes_pkg::aes_ctl_t ctl,
    output logic [127:0]    state_out
);
    import aes_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] k [16];
    logic [7:0] m [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127-8*i -: 8];
            k[i] = key_in[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                if (ctl.decrypt) begin
                    t[4*c+j] = sbox_rev(s[4*((c+4-j)%4)+j]);
                end else begin
                    t[4*c+j] = sbox(s[4*((c+j)%4)+j]);
                end
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (ctl.decrypt) begin
                for (int j = 0; j < 4; j++) u[4*c+j] = t[4*c+j] ^ k[4*c+j];
                for (int j = 0; j < 4; j++) begin
                    m[4*c+j] = gmul(u[4*c+j], 4'd14) ^ gmul(u[4*c+(j+1)%4], 4'd11)
                             ^ gmul(u[4*c+(j+2)%4], 4'd13) ^ gmul(u[4*c+(j+3)%4], 4'd9);
                end
            end else begin
                for (int j = 0; j < 4; j++) u[4*c+j] = t[4*c+j];
                for (int j = 0; j < 4; j++) begin
                    m[4*c+j] = gmul(u[4*c+j], 4'd2) ^ gmul(u[4*c+(j+1)%4], 4'd3)
                             ^ u[4*c+(j+2)%4] ^ u[4*c+(j+3)%4] ^ k[4*c+j];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (ctl.first) begin
                state_out[127-8*i -: 8] = s[i] ^ k[i];
            end else if (ctl.last) begin
                state_out[127-8*i -: 8] = t[i] ^ k[i];
            end else begin
                state_out[127-8*i -: 8] = m[i];
            end
        end
    end

endmodule

[src/aes256_cbc_cipher_checker.sv]
`include "aes256_cbc_cipher_macros.svh"
module aes256_cbc_cipher_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input aes_pkg::aes_out_t m_data
);
    `AES_ASSERT_IMPL(a_known, aclk, aresetn, m_valid, !$isunknown(m_data))
    `AES_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    `AES_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `AES_ASSERT_NEXT(a_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
endmodule

bind aes256_cbc_cipher aes256_cbc_cipher_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
